>>> hdl/adpa_pkg.sv
// shared types, codes and the rotate and condition-check helpers for the data-processing alu
package adpa_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FlagW = 4;

  // data-processing opcodes, instruction bits [24:21]
  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } opcode_t;

  // condition codes, instruction bits [31:28]
  typedef enum logic [3:0] {
    CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
    CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
    CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cond_t;

  // shift types, instruction bits [6:5]
  typedef enum logic [1:0] {
    SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
  } shift_t;

  // flag bit positions in nzcv
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  // rotate right by 0..31
  function automatic logic [WordW-1:0] ror32(input logic [WordW-1:0] v,
                                             input logic [4:0] k);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} >> k;
    return dbl[WordW-1:0];
  endfunction

  // condition check against nzcv
  function automatic logic cond_ok(input cond_t c, input logic [FlagW-1:0] f);
    logic n, z, cf, v, ok;
    n  = f[FlagN];
    z  = f[FlagZ];
    cf = f[FlagC];
    v  = f[FlagV];
    case (c)
      CC_EQ:   ok = z;
      CC_NE:   ok = !z;
      CC_CS:   ok = cf;
      CC_CC:   ok = !cf;
      CC_MI:   ok = n;
      CC_PL:   ok = !n;
      CC_VS:   ok = v;
      CC_VC:   ok = !v;
      CC_HI:   ok = cf && !z;
      CC_LS:   ok = !cf || z;
      CC_GE:   ok = (n == v);
      CC_LT:   ok = (n != v);
      CC_GT:   ok = !z && (n == v);
      CC_LE:   ok = z || (n != v);
      CC_AL:   ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> hdl/arm_data_processing_alu_top.sv
// data-processing execute stage: condition check, barrel shifter, alu and nzcv flags
// datapath: an instruction moves from the input register to the result register when the output is not stalled
// throughput: one instruction per cycle while out_stall is low; the shifter, adder and flag update sit in one
//   pass between the input register and the result register, and nzcv is written on
//   the same edge the result is loaded, so the next instruction sees it at once
// reset: synchronous active-low rst_n clears both valid bits and the nzcv flags
module arm_data_processing_alu_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [adpa_pkg::WordW-1:0] in_instr_word,
  input  logic [adpa_pkg::WordW-1:0] in_rn_value,
  input  logic [adpa_pkg::WordW-1:0] in_rm_value,
  input  logic [7:0]                in_rs_low_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [adpa_pkg::WordW-1:0] out_alu_result,
  output logic [3:0]                out_dest_index,
  output logic                      out_dest_write,
  output logic                      out_cond_passed,
  output logic [adpa_pkg::FlagW-1:0] out_flags_now
);
  import adpa_pkg::*;

  // input register
  logic              s1_valid_r;
  logic [WordW-1:0]  iw_r;
  logic [WordW-1:0]  rn_r;
  logic [WordW-1:0]  rm_r;
  logic [7:0]        rs_r;

  // architectural flags
  logic [FlagW-1:0]  flags_r;
  logic [FlagW-1:0]  flags_nxt;

  // result register
  logic              out_valid_r;
  logic [WordW-1:0]  res_r;
  logic [3:0]        rd_r;
  logic              dwr_r;
  logic              pass_r;
  logic [FlagW-1:0]  oflags_r;

  logic              advance;
  logic              load_in;

  // handshake control
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign load_in  = in_valid && !in_stall;

  // decode
  opcode_t           opc;
  cond_t             cc;
  shift_t            sh_type;
  logic              cin;
  logic              passed;
  logic              compare;
  logic              sbit;
  logic [3:0]        rd;
  logic [4:0]        imm_amt;
  logic [7:0]        amt;
  logic              rrx;

  assign opc     = opcode_t'(iw_r[24:21]);
  assign cc      = cond_t'(iw_r[31:28]);
  assign sh_type = shift_t'(iw_r[6:5]);
  assign cin     = flags_r[FlagC];
  assign passed  = cond_ok(cc, flags_r);
  assign compare = (opc == OP_TST) || (opc == OP_TEQ) || (opc == OP_CMP) || (opc == OP_CMN);
  assign sbit    = iw_r[20];
  assign rd      = iw_r[15:12];
  assign imm_amt = iw_r[11:7];

  // shift amount: immediate lsr/asr #0 mean 32, ror #0 means rrx
  always_comb begin
    rrx = 1'b0;
    if (iw_r[4]) begin
      amt = rs_r;
    end else if (imm_amt == 5'd0 && (sh_type == SH_LSR || sh_type == SH_ASR)) begin
      amt = 8'd32;
    end else begin
      amt = {3'b000, imm_amt};
      rrx = (imm_amt == 5'd0) && (sh_type == SH_ROR);
    end
  end

  // barrel shifter and immediate rotator
  logic [WordW-1:0]  op2;
  logic              sc;
  logic [WordW:0]    lsl_w;
  logic [WordW:0]    lsr_w;
  logic [WordW:0]    asr_w;
  logic [5:0]        asr_amt;
  logic [WordW-1:0]  ror_w;
  logic [4:0]        rot;

  assign lsl_w   = {1'b0, rm_r} << amt;
  assign lsr_w   = {rm_r, 1'b0} >> amt;
  assign asr_amt = (amt >= 8'd32) ? 6'd32 : amt[5:0];
  assign asr_w   = $unsigned($signed({rm_r, 1'b0}) >>> asr_amt);
  assign ror_w   = ror32(rm_r, amt[4:0]);
  assign rot     = {iw_r[11:8], 1'b0};

  always_comb begin
    if (iw_r[25]) begin
      op2 = ror32({24'd0, iw_r[7:0]}, rot);
      sc  = (rot == 5'd0) ? cin : op2[WordW-1];
    end else if (rrx) begin
      op2 = {cin, rm_r[WordW-1:1]};
      sc  = rm_r[0];
    end else if (amt == 8'd0) begin
      op2 = rm_r;
      sc  = cin;
    end else begin
      case (sh_type)
        SH_LSL: begin
          op2 = lsl_w[WordW-1:0];
          sc  = lsl_w[WordW];
        end
        SH_LSR: begin
          op2 = lsr_w[WordW:1];
          sc  = lsr_w[0];
        end
        SH_ASR: begin
          op2 = asr_w[WordW:1];
          sc  = asr_w[0];
        end
        default: begin
          op2 = ror_w;
          sc  = ror_w[WordW-1];
        end
      endcase
    end
  end

  // alu operand select
  logic [WordW-1:0]  add_a;
  logic [WordW-1:0]  add_b;
  logic              add_ci;
  logic              arith;
  logic [WordW-1:0]  logic_res;
  logic [WordW:0]    sum;

  always_comb begin
    add_a     = rn_r;
    add_b     = op2;
    add_ci    = 1'b0;
    arith     = 1'b1;
    logic_res = '0;
    case (opc)
      OP_AND, OP_TST: begin
        arith = 1'b0; logic_res = rn_r & op2;
      end
      OP_EOR, OP_TEQ: begin
        arith = 1'b0; logic_res = rn_r ^ op2;
      end
      OP_SUB, OP_CMP: begin
        add_b = ~op2; add_ci = 1'b1;
      end
      OP_RSB: begin
        add_a = op2; add_b = ~rn_r; add_ci = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        add_ci = 1'b0;
      end
      OP_ADC: begin
        add_ci = cin;
      end
      OP_SBC: begin
        add_b = ~op2; add_ci = cin;
      end
      OP_RSC: begin
        add_a = op2; add_b = ~rn_r; add_ci = cin;
      end
      OP_ORR: begin
        arith = 1'b0; logic_res = rn_r | op2;
      end
      OP_MOV: begin
        arith = 1'b0; logic_res = op2;
      end
      OP_BIC: begin
        arith = 1'b0; logic_res = rn_r & ~op2;
      end
      default: begin
        arith = 1'b0; logic_res = ~op2;
      end
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {{WordW{1'b0}}, add_ci};

  // result and flags
  logic [WordW-1:0]  res;
  logic              cf;
  logic              vf;
  logic              set_flags;
  logic [WordW-1:0]  res_nxt;
  logic              dwr_nxt;

  assign res       = arith ? sum[WordW-1:0] : logic_res;
  assign cf        = arith ? sum[WordW] : sc;
  assign vf        = arith ? ((add_a[WordW-1] ^ res[WordW-1]) & (add_b[WordW-1] ^ res[WordW-1]))
                           : flags_r[FlagV];
  assign set_flags = passed && (compare || (sbit && rd != 4'd15));
  assign flags_nxt = set_flags ? {res[WordW-1], (res == '0), cf, vf} : flags_r;
  assign res_nxt   = passed ? res : '0;
  assign dwr_nxt   = passed && !compare;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (load_in) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_in) begin
      iw_r <= in_instr_word;
      rn_r <= in_rn_value;
      rm_r <= in_rm_value;
      rs_r <= in_rs_low_byte;
    end
    if (advance) begin
      res_r    <= res_nxt;
      rd_r     <= rd;
      dwr_r    <= dwr_nxt;
      pass_r   <= passed;
      oflags_r <= flags_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_alu_result  = res_r;
  assign out_dest_index  = rd_r;
  assign out_dest_write  = dwr_r;
  assign out_cond_passed = pass_r;
  assign out_flags_now   = oflags_r;

  // a failed condition never writes and gives a zero result
  a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pass_r |-> !dwr_r && (res_r == '0))
    else $error("failed condition produced a write or nonzero result");

  // the shown flags always match the live flags while a result is held
  a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (oflags_r == flags_r))
    else $error("held result flags differ from architectural flags");

  // flags only change when an instruction moves to the result register
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flags_r))
    else $error("flags changed without a transfer");

  // flags come out of reset cleared
  a_flags_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (flags_r == '0))
    else $error("flags not cleared by reset");

endmodule
